### hw/rtl/interval_list_intersection_unit_defines.svh
// Assertion macros used by the interval list intersection datapath.
`ifndef INTERVAL_LIST_INTERSECTION_UNIT_DEFINES_SVH
`define INTERVAL_LIST_INTERSECTION_UNIT_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ILI_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ILI_ASSERT(label, prop, msg) \
  `ILI_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/ili_pkg.sv
// Types and constants of the interval list intersection unit.
package ili_pkg;

  localparam int DEPTH   = 32;
  localparam int ADDR_W  = 5;
  localparam int VAL_W   = 30;
  localparam int ENTRY_W = 2 * VAL_W;
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic flush;
  } ili_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic step_ok;
    logic out_free;
  } ili_sts_t;

endpackage

### hw/rtl/ili_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ili_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ili_ctrl.sv
// Controller state machine: decodes input words and sequences the walk.
module ili_ctrl
  import ili_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic [1:0] op_i,
  output logic      s_ready_o,
  output ili_cmd_t  cmd_o,
  input  ili_sts_t  sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign s_ready_o = (state_q == ST_IDLE);
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_a = take && (op_i == OP_LOAD_A);
        cmd_o.load_b = take && (op_i == OP_LOAD_B);
        if (take && (op_i == OP_RUN)) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.step = sts_i.step_ok;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/ili_dp.sv
// Datapath: interval stores, two-pointer compare, pending result and output register.
`include "interval_list_intersection_unit_defines.svh"

module ili_dp
  import ili_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ili_cmd_t           cmd_i,
  output ili_sts_t           sts_o,
  input  logic [ADDR_W-1:0]  slot_i,
  input  logic [VAL_W-1:0]   lo_bound_i,
  input  logic [VAL_W-1:0]   hi_bound_i,
  input  logic [CNT_W-1:0]   count_a_i,
  input  logic [CNT_W-1:0]   count_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_found_o,
  output logic [VAL_W-1:0]   out_start_o,
  output logic [VAL_W-1:0]   out_end_o,
  output logic               out_last_o
);

  logic [CNT_W-1:0]   pa_q, pa_d, pb_q, pb_d;
  logic [CNT_W-1:0]   ca_q, cb_q;
  logic [ENTRY_W-1:0] rd_a, rd_b, wdata;
  logic [VAL_W-1:0]   a_s, a_e, b_s, b_e, cut_s, cut_e;
  logic               hit, adv_a, out_free, step_ok, walk_done;

  logic               pend_v_q;
  logic [VAL_W-1:0]   pend_s_q, pend_e_q;
  logic               out_v_q, out_found_q, out_last_q;
  logic [VAL_W-1:0]   out_s_q, out_e_q;

  assign wdata = {hi_bound_i, lo_bound_i};

  ili_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_a),
    .waddr_i (slot_i),
    .wdata_i (wdata),
    .raddr_i (pa_d[ADDR_W-1:0]),
    .rdata_o (rd_a)
  );

  ili_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_b),
    .waddr_i (slot_i),
    .wdata_i (wdata),
    .raddr_i (pb_d[ADDR_W-1:0]),
    .rdata_o (rd_b)
  );

  assign a_s   = rd_a[VAL_W-1:0];
  assign a_e   = rd_a[ENTRY_W-1:VAL_W];
  assign b_s   = rd_b[VAL_W-1:0];
  assign b_e   = rd_b[ENTRY_W-1:VAL_W];
  assign cut_s = (a_s > b_s) ? a_s : b_s;
  assign cut_e = (a_e < b_e) ? a_e : b_e;
  assign hit   = (cut_s <= cut_e);
  assign adv_a = (a_e < b_e);

  assign out_free  = !out_v_q || out_ready_i;
  assign step_ok   = !(hit && pend_v_q && !out_free);
  assign walk_done = (pa_q >= ca_q) || (pb_q >= cb_q);

  assign sts_o.walk_done = walk_done;
  assign sts_o.step_ok   = step_ok;
  assign sts_o.out_free  = out_free;

  always_comb begin
    pa_d = pa_q;
    pb_d = pb_q;
    if (cmd_i.start) begin
      pa_d = '0;
      pb_d = '0;
    end else if (cmd_i.step) begin
      if (adv_a) begin
        pa_d = pa_q + CNT_W'(1);
      end else begin
        pb_d = pb_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q     <= '0;
      pb_q     <= '0;
      ca_q     <= '0;
      cb_q     <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      if ((cmd_i.step && hit && pend_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.start) begin
        ca_q <= (count_a_i > DEPTH_CNT) ? DEPTH_CNT : count_a_i;
        cb_q <= (count_b_i > DEPTH_CNT) ? DEPTH_CNT : count_b_i;
      end
      if (cmd_i.start || cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.step && hit) begin
        pend_v_q <= 1'b1;
      end
    end
  end

  // payload: the held hit moves out once a later hit or the end of the walk is seen
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && hit) begin
      pend_s_q <= cut_s;
      pend_e_q <= cut_e;
      if (pend_v_q) begin
        out_found_q <= 1'b1;
        out_s_q     <= pend_s_q;
        out_e_q     <= pend_e_q;
        out_last_q  <= 1'b0;
      end
    end
    if (cmd_i.flush) begin
      out_found_q <= pend_v_q;
      out_s_q     <= pend_v_q ? pend_s_q : '0;
      out_e_q     <= pend_v_q ? pend_e_q : '0;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_found_o = out_found_q;
  assign out_start_o = out_s_q;
  assign out_end_o   = out_e_q;
  assign out_last_o  = out_last_q;

  `ILI_ASSERT(a_step_no_overrun, cmd_i.step |-> (step_ok && !walk_done), "step while blocked")
  `ILI_ASSERT(a_ptr_in_range, (pa_q <= ca_q) && (pb_q <= cb_q), "pointer past count")
  `ILI_ASSERT(a_flush_clears, cmd_i.flush |=> (!pend_v_q && out_v_q && out_last_q), "flush lost")
  `ILI_ASSERT(a_miss_is_last, (out_v_q && !out_found_q) |-> out_last_q, "miss word not last")

endmodule

### hw/rtl/interval_list_intersection_unit.sv
// Top level of the interval list intersection unit.
//
//  channel  dir  tdata (low bit up)                              tuser  tlast
//  s_axis   in   slot, lo_bound, hi_bound, count_a, count_b, pad op     -
//  m_axis   out  cut_start, cut_end, pad                         found  last
//
// A load word writes one store entry. A run word walks both lists with
// one pointer step a cycle unless an output stall pauses it, the next entry
// address fed from the compare into the registered read of each store.
// Output stalls pause the walk only when a second hit has nowhere to go.
// Reset clears control only; store contents are undefined until loaded.
module interval_list_intersection_unit
  import ili_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // slot, lo_bound, hi_bound, count_a, count_b, pad
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // cut_start, cut_end, pad
  output logic        m_axis_tuser,  // found
  output logic        m_axis_tlast
);

  ili_cmd_t         cmd;
  ili_sts_t         sts;
  logic [VAL_W-1:0] cut_start, cut_end;

  ili_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ili_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .slot_i      (s_axis_tdata[4:0]),
    .lo_bound_i  (s_axis_tdata[34:5]),
    .hi_bound_i  (s_axis_tdata[64:35]),
    .count_a_i   (s_axis_tdata[70:65]),
    .count_b_i   (s_axis_tdata[76:71]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_start_o (cut_start),
    .out_end_o   (cut_end),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, cut_end, cut_start};

endmodule

### tb/tb_interval_list_intersection_unit.sv
// Self-checking testbench for the interval list intersection unit.
module tb_interval_list_intersection_unit;
  import ili_pkg::*;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic found;
    val_t cut_start;
    val_t cut_end;
    logic last;
  } hit_t;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam val_t        MAXV        = {VAL_W{1'b1}};
  localparam int unsigned END_WAIT    = 100;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_LOAD_A;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // shadow copies of both interval stores
  val_t a_lo [DEPTH];
  val_t a_hi [DEPTH];
  val_t b_lo [DEPTH];
  val_t b_hi [DEPTH];

  hit_t        hits_due [$];
  int unsigned mismatches = 0;
  int unsigned word_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  interval_list_intersection_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: random stalls and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    hit_t        got;
    hit_t        want;
    int unsigned stall;
    int unsigned d;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      stall = 0;
    end else if (m_axis_tvalid && m_ready) begin
      got.found     = m_axis_tuser;
      got.cut_start = m_axis_tdata[VAL_W-1:0];
      got.cut_end   = m_axis_tdata[2*VAL_W-1:VAL_W];
      got.last      = m_axis_tlast;
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: found=%0d start=%0d end=%0d last=%0d",
                   got.found, got.cut_start, got.cut_end, got.last);
      end else begin
        want = hits_due.pop_front();
        if (got.found !== want.found || got.cut_start !== want.cut_start ||
            got.cut_end !== want.cut_end || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.found, want.cut_start, want.cut_end, want.last,
                     got.found, got.cut_start, got.cut_end, got.last);
        end
      end
      d = rx_idle_on ? $urandom_range(0, 15) : 0;
      stall = d;
      m_ready <= (d == 0);
    end else if (stall != 0) begin
      stall--;
      m_ready <= (stall == 0);
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // hands one word over, then updates the stores or predicts the run
  task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] slot,
                           input val_t lo, input val_t hi,
                           input logic [CNT_W-1:0] ca, input logic [CNT_W-1:0] cb);
    int unsigned gap;
    int unsigned na;
    int unsigned nb;
    int unsigned pa;
    int unsigned pb;
    val_t        s;
    val_t        e;
    hit_t        h;
    hit_t        run_q [$];
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {3'b000, cb, ca, hi, lo, slot};
    s_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_NONE) word_cnt++;
    case (op)
      OP_LOAD_A: begin
        a_lo[slot] = lo;
        a_hi[slot] = hi;
      end
      OP_LOAD_B: begin
        b_lo[slot] = lo;
        b_hi[slot] = hi;
      end
      OP_RUN: begin
        na = (ca > DEPTH) ? DEPTH : ca;
        nb = (cb > DEPTH) ? DEPTH : cb;
        pa = 0;
        pb = 0;
        while (pa < na && pb < nb) begin
          s = (a_lo[pa] > b_lo[pb]) ? a_lo[pa] : b_lo[pb];
          e = (a_hi[pa] < b_hi[pb]) ? a_hi[pa] : b_hi[pb];
          if (s <= e) run_q.push_back('{1'b1, s, e, 1'b0});
          if (a_hi[pa] < b_hi[pb]) pa++;
          else pb++;
        end
        if (run_q.size() == 0) begin
          run_q.push_back('{1'b0, '0, '0, 1'b1});
        end else begin
          h = run_q.pop_back();
          h.last = 1'b1;
          run_q.push_back(h);
        end
        foreach (run_q[i]) hits_due.push_back(run_q[i]);
      end
      default: ;
    endcase
  endtask

  task automatic load_entry(input bit to_b, input int unsigned slot,
                            input val_t lo, input val_t hi);
    send_word(to_b ? OP_LOAD_B : OP_LOAD_A, ADDR_W'(slot), lo, hi,
              CNT_W'($urandom), CNT_W'($urandom));
  endtask

  task automatic run_walk(input int unsigned ca, input int unsigned cb);
    send_word(OP_RUN, ADDR_W'($urandom), val_t'($urandom), val_t'($urandom),
              CNT_W'(ca), CNT_W'(cb));
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (hits_due.size() != 0);
  endtask

  // sorted, disjoint list from slot 0 up; each entry grows by at most 3*spread+1
  task automatic fill_sorted(input bit to_b, input int unsigned n,
                             input longint unsigned base, input int unsigned spread);
    longint unsigned cur;
    longint unsigned lo;
    longint unsigned hi;
    cur = base;
    for (int unsigned i = 0; i < n; i++) begin
      lo  = cur + $urandom_range(0, spread);
      hi  = lo + $urandom_range(0, spread);
      load_entry(to_b, i, val_t'(lo), val_t'(hi));
      cur = hi + 1 + $urandom_range(0, spread);
    end
  endtask

  task automatic test_directed();
    load_entry(0, 0, 0, 5);
    load_entry(0, 1, 8, 20);
    load_entry(0, 2, 25, 25);
    load_entry(0, 3, val_t'(MAXV - 10), MAXV);
    load_entry(1, 0, 5, 9);
    load_entry(1, 1, 12, 20);
    load_entry(1, 2, 25, 40);
    load_entry(1, 3, MAXV, MAXV);
    run_walk(4, 4);
    run_walk(0, 4);
    run_walk(4, 0);
    send_word(OP_NONE, ADDR_W'($urandom), val_t'($urandom), val_t'($urandom),
              CNT_W'($urandom), CNT_W'($urandom));
    run_walk(1, 1);
    // end below start on A0
    load_entry(0, 0, 30, 10);
    run_walk(1, 2);
    run_walk(4, 4);
    load_entry(0, 0, 0, 5);
    run_walk(2, 2);
    wait_drained();
  endtask

  // leaves every entry of both stores written; later tests rely on it
  task automatic test_full_depth();
    fill_sorted(0, DEPTH, 0, 7);
    fill_sorted(1, DEPTH, 0, 7);
    run_walk(DEPTH, DEPTH);
    run_walk(63, DEPTH);
    run_walk(DEPTH + 1, 63);
    run_walk(DEPTH, 0);
    run_walk(DEPTH, 1);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned     goal;
    int unsigned     na;
    int unsigned     nb;
    int unsigned     spread;
    longint unsigned room;
    longint unsigned base;
    goal = word_cnt + 40;
    while (word_cnt < goal) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        na = $urandom_range(1, 6);
        nb = $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0:       spread = 3;
          1:       spread = 1000;
          default: spread = 1 << 20;
        endcase
        room = ((na > nb) ? na : nb) * (3 * spread + 1);
        case ($urandom_range(0, 2))
          0:       base = 0;
          1:       base = MAXV - room;
          default: base = $urandom_range(0, MAXV - room);
        endcase
        fill_sorted(0, na, base, spread);
        fill_sorted(1, nb, base, spread);
        if ($urandom_range(0, 3) != 0) run_walk(na, nb);
        else run_walk($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        repeat ($urandom_range(2, 5)) begin
          case ($urandom_range(0, 2))
            0: load_entry(0, $urandom_range(0, DEPTH - 1), val_t'($urandom), val_t'($urandom));
            1: load_entry(1, $urandom_range(0, DEPTH - 1), val_t'($urandom), val_t'($urandom));
            default: send_word(OP_NONE, ADDR_W'($urandom), val_t'($urandom),
                               val_t'($urandom), CNT_W'($urandom), CNT_W'($urandom));
          endcase
        end
        run_walk($urandom_range(0, 63), $urandom_range(0, 63));
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_depth();
    test_random();
    wait_drained();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && hits_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
